/* rtl/oddc_pkg.sv */
// Shared types and constants of the obstacle dodge controller.
package oddc_pkg;

  typedef logic [2:0] event_t;
  typedef logic signed [2:0] pos_t;
  typedef logic signed [5:0] speed_t;
  typedef logic [3:0] leds_t;
  typedef logic [7:0] level_t;
  typedef logic [1:0] cfg_idx_t;
  typedef logic [1:0] key_t;

  localparam event_t EV_NONE     = 3'd0;
  localparam event_t EV_DETECTED = 3'd4;
  localparam event_t EV_CLEAR    = 3'd5;
  localparam event_t EV_CLEAR_L  = 3'd6;
  localparam event_t EV_CLEAR_R  = 3'd7;

  localparam key_t KEY_NONE = 2'd0;

  localparam cfg_idx_t REG_DETECT = 2'd0;
  localparam cfg_idx_t REG_CLEAR  = 2'd1;
  localparam cfg_idx_t REG_SIDE   = 2'd2;

  localparam level_t DETECT_RST = 8'd25;
  localparam level_t CLEAR_RST  = 8'd20;
  localparam level_t SIDE_RST   = 8'd5;

  localparam pos_t POS_FAR_L  = -3'sd2;
  localparam pos_t POS_NEAR_L = -3'sd1;
  localparam pos_t POS_MID    = 3'sd0;
  localparam pos_t POS_NEAR_R = 3'sd1;
  localparam pos_t POS_FAR_R  = 3'sd2;

  localparam speed_t SPD_STOP    = 6'sd0;
  localparam speed_t SPD_BACK    = -6'sd25;
  localparam speed_t SPD_SLOW    = 6'sd15;
  localparam speed_t SPD_REVERSE = -6'sd20;
  localparam speed_t SPD_FULL    = 6'sd30;
  localparam speed_t SPD_TURN    = 6'sd20;

  localparam leds_t LED_OFF     = 4'h0;
  localparam leds_t LED_STOPPED = 4'h9;
  localparam leds_t LED_1       = 4'h1;
  localparam leds_t LED_2       = 4'h2;
  localparam leds_t LED_3       = 4'h4;
  localparam leds_t LED_4       = 4'h8;

  localparam logic [6:0] HALF_MAX = 7'd127;

endpackage

/* rtl/obstacle_dodge_controller_core.sv */
// Top level of the obstacle dodge controller: sensor grading, events and drive state.
// An input waits in the input register, which frees as the result register takes its result.
// Throughput: one beat per cycle while out_ready does not stall the output.
// A stalled result holds the output stage, and the input register takes one more beat.
// Reset (rst_n low, synchronous) empties both stages, clears run, event, speed, LED and
// position state, and loads the thresholds with 25, 20 and 5.
module obstacle_dodge_controller_core #(
  parameter int SENSOR_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_key_code,
  input  logic [SENSOR_BITS-1:0]          in_sensor_far_left,
  input  logic [SENSOR_BITS-1:0]          in_sensor_left,
  input  logic [SENSOR_BITS-1:0]          in_sensor_right,
  input  logic [SENSOR_BITS-1:0]          in_sensor_far_right,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_event_code,
  output logic signed [2:0]               out_obstacle_position,
  output logic [7:0]                      out_obstacle_level,
  output logic                            out_running,
  output logic signed [5:0]               out_left_speed,
  output logic signed [5:0]               out_right_speed,
  output logic [3:0]                      out_led_pattern,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [7:0]                      cfg_data
);

  localparam logic [SENSOR_BITS-1:0] CLAMP = SENSOR_BITS'(255);

  oddc_pkg::level_t detect_r, clear_r, side_r;

  logic                   s1_valid_r;
  oddc_pkg::key_t         s1_key_r;
  logic [SENSOR_BITS-1:0] s1_fl_r, s1_l_r, s1_r_r, s1_fr_r;

  logic                   out_valid_r;
  oddc_pkg::event_t       out_event_r;
  oddc_pkg::level_t       out_level_r;

  logic                   run_r, run_nxt;
  oddc_pkg::event_t       last_r, last_nxt;
  oddc_pkg::speed_t       lspd_r, lspd_nxt, rspd_r, rspd_nxt;
  oddc_pkg::leds_t        leds_r, leds_nxt;
  oddc_pkg::pos_t         pos_r, pos_nxt;

  oddc_pkg::event_t       event_nxt, obs;
  oddc_pkg::level_t       level_nxt, lvl, sum_ll, sum_cc, sum_rr, lvl_a;
  logic [6:0]             h_fl, h_l, h_r, h_fr;
  logic                   advance;

  function automatic logic [6:0] half_reading(input logic [SENSOR_BITS-1:0] raw);
    half_reading = (raw > CLAMP) ? oddc_pkg::HALF_MAX : raw[7:1];
  endfunction

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign h_fl   = half_reading(s1_fl_r);
  assign h_l    = half_reading(s1_l_r);
  assign h_r    = half_reading(s1_r_r);
  assign h_fr   = half_reading(s1_fr_r);
  assign sum_ll = {1'b0, h_fl} + {1'b0, h_l};
  assign sum_cc = {1'b0, h_l} + {1'b0, h_r};
  assign sum_rr = {1'b0, h_r} + {1'b0, h_fr};
  assign lvl_a  = (sum_cc > sum_ll) ? sum_cc : sum_ll;
  assign lvl    = (sum_rr > lvl_a) ? sum_rr : lvl_a;

  always_comb begin
    event_nxt = oddc_pkg::EV_NONE;
    level_nxt = '0;
    run_nxt   = run_r;
    last_nxt  = last_r;
    lspd_nxt  = lspd_r;
    rspd_nxt  = rspd_r;
    leds_nxt  = leds_r;
    pos_nxt   = pos_r;
    obs       = oddc_pkg::EV_NONE;

    if (s1_key_r != oddc_pkg::KEY_NONE) begin
      event_nxt = oddc_pkg::event_t'({1'b0, s1_key_r});
    end else begin
      level_nxt = lvl;
      if (lvl == sum_cc || sum_ll == sum_rr) begin
        if (sum_ll > sum_rr) begin
          pos_nxt = oddc_pkg::POS_NEAR_L;
        end else if (sum_ll < sum_rr) begin
          pos_nxt = oddc_pkg::POS_NEAR_R;
        end else begin
          pos_nxt = oddc_pkg::POS_MID;
        end
      end else if (sum_ll > sum_rr) begin
        pos_nxt = oddc_pkg::POS_FAR_L;
      end else begin
        pos_nxt = oddc_pkg::POS_FAR_R;
      end

      if (lvl > detect_r) begin
        obs = oddc_pkg::EV_DETECTED;
      end
      if (lvl < clear_r) begin
        obs = oddc_pkg::EV_CLEAR;
        if (lvl > side_r) begin
          if (pos_nxt < 0) begin
            obs = oddc_pkg::EV_CLEAR_R;
          end else if (pos_nxt > 0) begin
            obs = oddc_pkg::EV_CLEAR_L;
          end
        end
      end
      if (obs != last_r) begin
        last_nxt  = obs;
        event_nxt = obs;
      end
    end

    if (!run_r) begin
      if (s1_key_r != oddc_pkg::KEY_NONE) begin
        run_nxt  = 1'b1;
        last_nxt = oddc_pkg::EV_NONE;
      end
    end else if (s1_key_r != oddc_pkg::KEY_NONE) begin
      run_nxt  = 1'b0;
      lspd_nxt = oddc_pkg::SPD_STOP;
      rspd_nxt = oddc_pkg::SPD_STOP;
      leds_nxt = oddc_pkg::LED_STOPPED;
    end else begin
      case (event_nxt)
        oddc_pkg::EV_DETECTED: begin
          leds_nxt = ((pos_nxt <= 0) ? oddc_pkg::LED_1 : oddc_pkg::LED_OFF)
                   | ((pos_nxt >= 0) ? oddc_pkg::LED_4 : oddc_pkg::LED_OFF);
          if (pos_nxt > 0) begin
            lspd_nxt = oddc_pkg::SPD_BACK;
            rspd_nxt = oddc_pkg::SPD_SLOW;
          end else if (pos_nxt < 0) begin
            lspd_nxt = oddc_pkg::SPD_SLOW;
            rspd_nxt = oddc_pkg::SPD_BACK;
          end else begin
            lspd_nxt = oddc_pkg::SPD_REVERSE;
            rspd_nxt = oddc_pkg::SPD_REVERSE;
          end
        end
        oddc_pkg::EV_CLEAR: begin
          leds_nxt = oddc_pkg::LED_OFF;
          lspd_nxt = oddc_pkg::SPD_FULL;
          rspd_nxt = oddc_pkg::SPD_FULL;
        end
        oddc_pkg::EV_CLEAR_L: begin
          leds_nxt = oddc_pkg::LED_3;
          lspd_nxt = oddc_pkg::SPD_TURN;
          rspd_nxt = oddc_pkg::SPD_FULL;
        end
        oddc_pkg::EV_CLEAR_R: begin
          leds_nxt = oddc_pkg::LED_2;
          lspd_nxt = oddc_pkg::SPD_FULL;
          rspd_nxt = oddc_pkg::SPD_TURN;
        end
        default: begin
          leds_nxt = leds_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detect_r <= oddc_pkg::DETECT_RST;
      clear_r  <= oddc_pkg::CLEAR_RST;
      side_r   <= oddc_pkg::SIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        oddc_pkg::REG_DETECT: detect_r <= cfg_data;
        oddc_pkg::REG_CLEAR:  clear_r  <= cfg_data;
        oddc_pkg::REG_SIDE:   side_r   <= cfg_data;
        default: begin
          side_r <= side_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_key_r <= in_key_code;
      s1_fl_r  <= in_sensor_far_left;
      s1_l_r   <= in_sensor_left;
      s1_r_r   <= in_sensor_right;
      s1_fr_r  <= in_sensor_far_right;
    end
    if (advance) begin
      out_event_r <= event_nxt;
      out_level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      run_r       <= 1'b0;
      last_r      <= oddc_pkg::EV_NONE;
      lspd_r      <= oddc_pkg::SPD_STOP;
      rspd_r      <= oddc_pkg::SPD_STOP;
      leds_r      <= oddc_pkg::LED_OFF;
      pos_r       <= oddc_pkg::POS_MID;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        run_r       <= run_nxt;
        last_r      <= last_nxt;
        lspd_r      <= lspd_nxt;
        rspd_r      <= rspd_nxt;
        leds_r      <= leds_nxt;
        pos_r       <= pos_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_event_code        = out_event_r;
  assign out_obstacle_level    = out_level_r;
  assign out_obstacle_position = pos_r;
  assign out_running           = run_r;
  assign out_left_speed        = lspd_r;
  assign out_right_speed       = rspd_r;
  assign out_led_pattern       = leds_r;

endmodule

/* rtl/oddc_checker.sv */
// Port-level assertions for the obstacle dodge controller and their binding.
module oddc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [2:0]        out_event_code,
  input logic signed [2:0] out_obstacle_position,
  input logic [7:0]        out_obstacle_level,
  input logic              out_running,
  input logic signed [5:0] out_left_speed,
  input logic signed [5:0] out_right_speed,
  input logic [3:0]        out_led_pattern
);

  logic key_beat;

  assign key_beat = out_event_code == 3'd1 || out_event_code == 3'd2
                 || out_event_code == 3'd3;

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result beat offered right after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_code)
      && $stable(out_obstacle_level) && $stable(out_led_pattern))
    else $error("Stalled result beat changed.");

  a_key_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && key_beat |-> out_obstacle_level == 8'd0)
    else $error("Key beat carries a nonzero obstacle level.");

  a_key_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && key_beat && !out_running |-> out_left_speed == 6'sd0
      && out_right_speed == 6'sd0 && out_led_pattern == oddc_pkg::LED_STOPPED)
    else $error("Stop by key did not halt the wheels.");

  a_clear_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_running && out_event_code == oddc_pkg::EV_CLEAR
      |-> out_left_speed == oddc_pkg::SPD_FULL
      && out_right_speed == oddc_pkg::SPD_FULL
      && out_led_pattern == oddc_pkg::LED_OFF)
    else $error("Clear beat while running did not set full speed.");

endmodule

bind obstacle_dodge_controller_core oddc_checker u_oddc_checker (.*);

/* tb/obstacle_dodge_controller_core_test.sv */
// Self-checking testbench for the obstacle dodge controller core.
`timescale 1ns / 100ps

module obstacle_dodge_controller_core_test;

  localparam int SENSOR_BITS = 10;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 172;

  typedef logic [SENSOR_BITS-1:0] sensor_t;

  typedef struct packed {
    oddc_pkg::event_t ev;
    oddc_pkg::pos_t   pos;
    oddc_pkg::level_t lvl;
    logic             run;
    oddc_pkg::speed_t lspd;
    oddc_pkg::speed_t rspd;
    oddc_pkg::leds_t  leds;
  } result_t;

  typedef struct {
    bit                 is_cfg;
    oddc_pkg::cfg_idx_t idx;
    oddc_pkg::level_t   val;
    oddc_pkg::key_t     key;
    sensor_t            fl;
    sensor_t            l;
    sensor_t            r;
    sensor_t            fr;
    bit                 typed;
    result_t            want;
  } step_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  oddc_pkg::key_t in_key_code;
  sensor_t in_sensor_far_left;
  sensor_t in_sensor_left;
  sensor_t in_sensor_right;
  sensor_t in_sensor_far_right;
  logic out_valid;
  logic out_ready;
  logic [2:0] out_event_code;
  logic signed [2:0] out_obstacle_position;
  logic [7:0] out_obstacle_level;
  logic out_running;
  logic signed [5:0] out_left_speed;
  logic signed [5:0] out_right_speed;
  logic [3:0] out_led_pattern;
  logic cfg_valid;
  logic cfg_ready;
  oddc_pkg::cfg_idx_t cfg_index;
  logic [7:0] cfg_data;

  oddc_pkg::level_t det_lvl = oddc_pkg::DETECT_RST;
  oddc_pkg::level_t clr_lvl = oddc_pkg::CLEAR_RST;
  oddc_pkg::level_t side_lvl = oddc_pkg::SIDE_RST;
  logic run_st = 1'b0;
  oddc_pkg::event_t last_ev = oddc_pkg::EV_NONE;
  oddc_pkg::speed_t held_l = oddc_pkg::SPD_STOP;
  oddc_pkg::speed_t held_r = oddc_pkg::SPD_STOP;
  oddc_pkg::leds_t held_leds = oddc_pkg::LED_OFF;
  oddc_pkg::pos_t held_pos = oddc_pkg::POS_MID;

  // Expected result beats, oldest first.
  result_t result_q[$];
  step_t plan[$];

  bit quiet = 1'b0;
  int stall_left = 0;
  int stuck_cycles = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_cfg = 0;
  int n_results = 0;
  int n_key = 0;
  int n_det = 0;
  int n_clr = 0;

  obstacle_dodge_controller_core #(
    .SENSOR_BITS(SENSOR_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_key_code(in_key_code),
    .in_sensor_far_left(in_sensor_far_left),
    .in_sensor_left(in_sensor_left),
    .in_sensor_right(in_sensor_right),
    .in_sensor_far_right(in_sensor_far_right),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_event_code(out_event_code),
    .out_obstacle_position(out_obstacle_position),
    .out_obstacle_level(out_obstacle_level),
    .out_running(out_running),
    .out_left_speed(out_left_speed),
    .out_right_speed(out_right_speed),
    .out_led_pattern(out_led_pattern),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int halve(sensor_t raw);
    return (raw > 255 ? 255 : int'(raw)) >> 1;
  endfunction

  function automatic result_t predict_update(oddc_pkg::key_t key, sensor_t fl, sensor_t l,
                                             sensor_t r, sensor_t fr);
    result_t res;
    int sum_l;
    int sum_c;
    int sum_r;
    int lvl;
    oddc_pkg::event_t obs;
    oddc_pkg::event_t ev;
    ev = oddc_pkg::EV_NONE;
    lvl = 0;
    if (key != oddc_pkg::KEY_NONE) begin
      ev = oddc_pkg::event_t'(key);
    end else begin
      sum_l = halve(fl) + halve(l);
      sum_c = halve(l) + halve(r);
      sum_r = halve(r) + halve(fr);
      lvl = sum_l;
      if (sum_c > lvl) lvl = sum_c;
      if (sum_r > lvl) lvl = sum_r;
      if (lvl == sum_c || sum_l == sum_r) begin
        held_pos = sum_l > sum_r ? oddc_pkg::POS_NEAR_L :
                   (sum_l < sum_r ? oddc_pkg::POS_NEAR_R : oddc_pkg::POS_MID);
      end else begin
        held_pos = sum_l > sum_r ? oddc_pkg::POS_FAR_L : oddc_pkg::POS_FAR_R;
      end
      obs = oddc_pkg::EV_NONE;
      if (lvl > det_lvl) obs = oddc_pkg::EV_DETECTED;
      if (lvl < clr_lvl) begin
        obs = oddc_pkg::EV_CLEAR;
        if (lvl > side_lvl) begin
          if (held_pos < oddc_pkg::POS_MID) obs = oddc_pkg::EV_CLEAR_R;
          else if (held_pos > oddc_pkg::POS_MID) obs = oddc_pkg::EV_CLEAR_L;
        end
      end
      if (obs != last_ev) begin
        last_ev = obs;
        ev = obs;
      end
    end

    if (!run_st) begin
      if (key != oddc_pkg::KEY_NONE) begin
        run_st = 1'b1;
        last_ev = oddc_pkg::EV_NONE;
      end
    end else if (key != oddc_pkg::KEY_NONE) begin
      run_st = 1'b0;
      held_l = oddc_pkg::SPD_STOP;
      held_r = oddc_pkg::SPD_STOP;
      held_leds = oddc_pkg::LED_STOPPED;
    end else begin
      case (ev)
        oddc_pkg::EV_DETECTED: begin
          held_leds = (held_pos <= oddc_pkg::POS_MID ? oddc_pkg::LED_1 : oddc_pkg::LED_OFF) |
                      (held_pos >= oddc_pkg::POS_MID ? oddc_pkg::LED_4 : oddc_pkg::LED_OFF);
          if (held_pos > oddc_pkg::POS_MID) begin
            held_l = oddc_pkg::SPD_BACK;
            held_r = oddc_pkg::SPD_SLOW;
          end else if (held_pos < oddc_pkg::POS_MID) begin
            held_l = oddc_pkg::SPD_SLOW;
            held_r = oddc_pkg::SPD_BACK;
          end else begin
            held_l = oddc_pkg::SPD_REVERSE;
            held_r = oddc_pkg::SPD_REVERSE;
          end
        end
        oddc_pkg::EV_CLEAR: begin
          held_leds = oddc_pkg::LED_OFF;
          held_l = oddc_pkg::SPD_FULL;
          held_r = oddc_pkg::SPD_FULL;
        end
        oddc_pkg::EV_CLEAR_L: begin
          held_leds = oddc_pkg::LED_3;
          held_l = oddc_pkg::SPD_TURN;
          held_r = oddc_pkg::SPD_FULL;
        end
        oddc_pkg::EV_CLEAR_R: begin
          held_leds = oddc_pkg::LED_2;
          held_l = oddc_pkg::SPD_FULL;
          held_r = oddc_pkg::SPD_TURN;
        end
        default: begin
        end
      endcase
    end

    res.ev = ev;
    res.pos = held_pos;
    res.lvl = oddc_pkg::level_t'(lvl);
    res.run = run_st;
    res.lspd = held_l;
    res.rspd = held_r;
    res.leds = held_leds;
    return res;
  endfunction

  function automatic void add_item(oddc_pkg::key_t key, sensor_t fl, sensor_t l, sensor_t r,
                                   sensor_t fr);
    step_t s;
    s.is_cfg = 1'b0;
    s.idx = oddc_pkg::REG_DETECT;
    s.val = '0;
    s.key = key;
    s.fl = fl;
    s.l = l;
    s.r = r;
    s.fr = fr;
    s.typed = 1'b0;
    s.want = '0;
    plan.push_back(s);
  endfunction

  function automatic void typed_last(oddc_pkg::event_t ev, oddc_pkg::pos_t pos,
                                     oddc_pkg::level_t lvl, logic run, oddc_pkg::speed_t ls,
                                     oddc_pkg::speed_t rs, oddc_pkg::leds_t leds);
    step_t s;
    s = plan.pop_back();
    s.typed = 1'b1;
    s.want = '{ev, pos, lvl, run, ls, rs, leds};
    plan.push_back(s);
  endfunction

  function automatic void add_cfg(oddc_pkg::cfg_idx_t idx, oddc_pkg::level_t val);
    step_t s;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    s.key = oddc_pkg::KEY_NONE;
    s.fl = '0;
    s.l = '0;
    s.r = '0;
    s.fr = '0;
    s.typed = 1'b0;
    s.want = '0;
    plan.push_back(s);
  endfunction

  function automatic sensor_t pick_reading();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return sensor_t'($urandom_range(0, 60));
    if (sel < 9) return sensor_t'($urandom_range(0, 1023));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return sensor_t'(255);
      default: return sensor_t'(256);
    endcase
  endfunction

  task automatic send_item(oddc_pkg::key_t key, sensor_t fl, sensor_t l, sensor_t r,
                           sensor_t fr, bit typed, result_t want);
    result_t pred;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_code <= key;
    in_sensor_far_left <= fl;
    in_sensor_left <= l;
    in_sensor_right <= r;
    in_sensor_far_right <= fr;
    do @(posedge clk); while (!in_ready);
    pred = predict_update(key, fl, l, r, fr);
    result_q.push_back(typed ? want : pred);
    n_items++;
  endtask

  task automatic write_reg(oddc_pkg::cfg_idx_t idx, oddc_pkg::level_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      oddc_pkg::REG_DETECT: det_lvl = val;
      oddc_pkg::REG_CLEAR: clr_lvl = val;
      oddc_pkg::REG_SIDE: side_lvl = val;
      default: begin
      end
    endcase
    n_cfg++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic report(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: expected ev=%0d pos=%0d lvl=%0d run=%0b l=%0d r=%0d leds=%h", $time,
               what, want.ev, want.pos, want.lvl, want.run, want.lspd, want.rspd, want.leds);
      $display("    got ev=%0d pos=%0d lvl=%0d run=%0b l=%0d r=%0d leds=%h", got.ev, got.pos,
               got.lvl, got.run, got.lspd, got.rspd, got.leds);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_event_code, out_obstacle_position, out_obstacle_level, out_running,
              out_left_speed, out_right_speed, out_led_pattern};
      if (result_q.size() == 0) begin
        report("beat with nothing expected", '0, got);
      end else begin
        want = result_q.pop_front();
        n_results++;
        case (want.ev)
          oddc_pkg::EV_NONE: begin
          end
          oddc_pkg::EV_DETECTED: n_det++;
          oddc_pkg::EV_CLEAR, oddc_pkg::EV_CLEAR_L, oddc_pkg::EV_CLEAR_R: n_clr++;
          default: n_key++;
        endcase
        if (got.ev !== want.ev || got.pos !== want.pos || got.lvl !== want.lvl ||
            got.run !== want.run || got.lspd !== want.lspd || got.rspd !== want.rspd ||
            got.leds !== want.leds) begin
          report("mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("Handshake timeout after %0d idle cycles.", stuck_cycles);
        $display("obstacle_dodge_controller_core_test: errors");
        $finish;
      end
    end
  end

  initial begin
    oddc_pkg::key_t key;
    int dv;
    int cv;
    int sv;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_key_code = oddc_pkg::KEY_NONE;
    in_sensor_far_left = '0;
    in_sensor_left = '0;
    in_sensor_right = '0;
    in_sensor_far_right = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = oddc_pkg::REG_DETECT;
    cfg_data = '0;

    add_item(oddc_pkg::KEY_NONE, 10'd0, 10'd0, 10'd0, 10'd0);
    typed_last(oddc_pkg::EV_CLEAR, oddc_pkg::POS_MID, 8'd0, 1'b0, oddc_pkg::SPD_STOP,
               oddc_pkg::SPD_STOP, oddc_pkg::LED_OFF);
    add_item(oddc_pkg::KEY_NONE, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    typed_last(oddc_pkg::EV_DETECTED, oddc_pkg::POS_MID, 8'd254, 1'b0, oddc_pkg::SPD_STOP,
               oddc_pkg::SPD_STOP, oddc_pkg::LED_OFF);
    add_item(2'd1, 10'd0, 10'd0, 10'd0, 10'd0);
    typed_last(3'd1, oddc_pkg::POS_MID, 8'd0, 1'b1, oddc_pkg::SPD_STOP, oddc_pkg::SPD_STOP,
               oddc_pkg::LED_OFF);
    add_item(oddc_pkg::KEY_NONE, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    typed_last(oddc_pkg::EV_DETECTED, oddc_pkg::POS_MID, 8'd254, 1'b1, oddc_pkg::SPD_REVERSE,
               oddc_pkg::SPD_REVERSE, oddc_pkg::LED_1 | oddc_pkg::LED_4);
    add_item(oddc_pkg::KEY_NONE, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    typed_last(oddc_pkg::EV_NONE, oddc_pkg::POS_MID, 8'd254, 1'b1, oddc_pkg::SPD_REVERSE,
               oddc_pkg::SPD_REVERSE, oddc_pkg::LED_1 | oddc_pkg::LED_4);
    add_item(oddc_pkg::KEY_NONE, 10'd1023, 10'd0, 10'd0, 10'd0);
    add_item(oddc_pkg::KEY_NONE, 10'd0, 10'd200, 10'd0, 10'd0);
    add_item(oddc_pkg::KEY_NONE, 10'd20, 10'd0, 10'd0, 10'd0);
    add_item(oddc_pkg::KEY_NONE, 10'd0, 10'd0, 10'd0, 10'd20);
    add_item(oddc_pkg::KEY_NONE, 10'd0, 10'd10, 10'd10, 10'd0);
    add_item(oddc_pkg::KEY_NONE, 10'd44, 10'd0, 10'd0, 10'd0);
    add_item(oddc_pkg::KEY_NONE, 10'd0, 10'd0, 10'd0, 10'd1023);
    add_item(oddc_pkg::KEY_NONE, 10'd44, 10'd0, 10'd0, 10'd0);
    add_item(oddc_pkg::KEY_NONE, 10'd1023, 10'd0, 10'd0, 10'd0);
    add_item(oddc_pkg::KEY_NONE, 10'd256, 10'd512, 10'd300, 10'd768);
    add_item(2'd2, 10'd5, 10'd5, 10'd5, 10'd5);
    add_item(oddc_pkg::KEY_NONE, 10'd20, 10'd0, 10'd0, 10'd0);
    add_item(oddc_pkg::KEY_NONE, 10'd0, 10'd0, 10'd0, 10'd1023);
    add_item(2'd3, 10'd0, 10'd0, 10'd0, 10'd0);
    add_cfg(oddc_pkg::REG_DETECT, 8'd10);
    add_cfg(oddc_pkg::REG_CLEAR, 8'd200);
    add_cfg(oddc_pkg::REG_SIDE, 8'd254);
    add_item(oddc_pkg::KEY_NONE, 10'd0, 10'd200, 10'd0, 10'd0);
    add_item(oddc_pkg::KEY_NONE, 10'd0, 10'd0, 10'd0, 10'd0);
    add_cfg(oddc_pkg::REG_SIDE, 8'd0);
    add_item(oddc_pkg::KEY_NONE, 10'd100, 10'd0, 10'd0, 10'd0);
    add_cfg(oddc_pkg::REG_DETECT, 8'd254);
    add_cfg(oddc_pkg::REG_CLEAR, 8'd0);
    add_item(oddc_pkg::KEY_NONE, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    add_item(oddc_pkg::KEY_NONE, 10'd0, 10'd0, 10'd0, 10'd0);
    add_cfg(oddc_pkg::REG_DETECT, 8'd0);
    add_item(oddc_pkg::KEY_NONE, 10'd2, 10'd0, 10'd0, 10'd0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_item(plan[i].key, plan[i].fl, plan[i].l, plan[i].r, plan[i].fr, plan[i].typed,
                  plan[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          dv = oddc_pkg::DETECT_RST;
          cv = oddc_pkg::CLEAR_RST;
          sv = oddc_pkg::SIDE_RST;
        end
        1: begin
          dv = 254;
          cv = 0;
          sv = 0;
        end
        2: begin
          dv = 0;
          cv = 254;
          sv = 254;
        end
        default: begin
          dv = $urandom_range(8, 80);
          cv = $urandom_range(0, dv);
          sv = $urandom_range(0, cv);
          if ($urandom_range(0, 3) == 0) begin
            dv = $urandom_range(0, 254);
            cv = $urandom_range(0, 254);
            sv = $urandom_range(0, 254);
          end
        end
      endcase
      wait_idle();
      write_reg(oddc_pkg::REG_DETECT, oddc_pkg::level_t'(dv));
      wait_idle();
      write_reg(oddc_pkg::REG_CLEAR, oddc_pkg::level_t'(cv));
      wait_idle();
      write_reg(oddc_pkg::REG_SIDE, oddc_pkg::level_t'(sv));
      quiet = (phase == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        key = ($urandom_range(0, 15) == 0) ? oddc_pkg::key_t'($urandom_range(1, 3))
                                           : oddc_pkg::KEY_NONE;
        send_item(key, pick_reading(), pick_reading(), pick_reading(), pick_reading(), 1'b0,
                  '0);
      end
    end

    wait_idle();
    $display("Sent %0d sensor updates over %0d threshold settings (%0d register writes).",
             n_items, PHASES + 4, n_cfg);
    $display("Checked %0d result beats: %0d key, %0d detected, %0d clear events; %0d mismatches.",
             n_results, n_key, n_det, n_clr, mismatches);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("obstacle_dodge_controller_core_test: clean");
    end else begin
      $display("obstacle_dodge_controller_core_test: errors");
    end
    $finish;
  end

endmodule
